// ===== design/prc_pkg.sv =====
// Shared types and constants for the pose regulation controller.
package prc_pkg;

   // Register indexes of the configuration port
   typedef enum logic [2:0] {
      CSR_GAIN_DISTANCE      = 3'd0,
      CSR_GAIN_BEARING       = 3'd1,
      CSR_GAIN_FINAL_HEADING = 3'd2,
      CSR_GOAL_X             = 3'd3,
      CSR_GOAL_Y             = 3'd4,
      CSR_GOAL_HEADING       = 3'd5,
      CSR_MAX_LINEAR         = 3'd6,
      CSR_MAX_ANGULAR        = 3'd7
   } csr_index_type;

   localparam int unsigned POS_W   = 24;
   localparam int unsigned HEAD_W  = 16;
   localparam int unsigned GAIN_W  = 16;
   localparam int unsigned LIM_W   = 23;
   localparam int unsigned CSR_IDX_W = 4;
   localparam int unsigned CSR_DAT_W = 24;

   // CORDIC datapath: dx*16 fits in 29 bits, growth below 1.65 adds one more
   localparam int unsigned CW = 32;

   localparam logic [29:0] INVK_Q30 = 30'd652032874;
   localparam logic [22:0] PI_Q21   = 23'd6588397;

   // atan(2^-i) as fraction of a full turn, 32 bits
   localparam logic [31:0] ATAN_TURN32 [24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // Configuration registers as one bundle
   typedef struct packed {
      logic [GAIN_W-1:0] gain_distance;
      logic [GAIN_W-1:0] gain_bearing;
      logic [GAIN_W-1:0] gain_final_heading;
      logic [POS_W-1:0]  goal_x;
      logic [POS_W-1:0]  goal_y;
      logic [HEAD_W-1:0] goal_heading;
      logic [LIM_W-1:0]  max_linear;
      logic [LIM_W-1:0]  max_angular;
   } cfg_type;

endpackage

// ===== design/prc_cordic.sv =====
// Pipelined vectoring CORDIC: magnitude (unscaled) and bearing of (dx, dy).
module prc_cordic import prc_pkg::*; #(
   parameter int unsigned ANGLE_BITS    = 16,
   parameter int unsigned CORDIC_STAGES = 16,
   parameter int unsigned SIDE_W        = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic signed [CW-1:0]  in_x,
   input  logic signed [CW-1:0]  in_y,
   input  logic                  in_zero,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic signed [CW-1:0]  out_x,
   output logic [ANGLE_BITS-1:0] out_z,
   output logic                  out_zero,
   output logic [SIDE_W-1:0]     out_side
);

   localparam int unsigned N = CORDIC_STAGES + 1;

   logic                  v_ff    [N];
   logic signed [CW-1:0]  x_ff    [N];
   logic signed [CW-1:0]  y_ff    [N];
   logic [ANGLE_BITS-1:0] z_ff    [N];
   logic                  zero_ff [N];
   logic [SIDE_W-1:0]     side_ff [N];

   // Stage 0: fold into right half plane
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff[0] <= in_zero;
         side_ff[0] <= in_side;
         if (in_x < 0) begin
            x_ff[0] <= -in_x;
            y_ff[0] <= -in_y;
            z_ff[0] <= ANGLE_BITS'(1) << (ANGLE_BITS - 1);
         end else begin
            x_ff[0] <= in_x;
            y_ff[0] <= in_y;
            z_ff[0] <= '0;
         end
      end
   end

   // One micro-rotation per stage
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      localparam logic [32:0] ROUNDED =
         {1'b0, ATAN_TURN32[i]} + (33'd1 << (31 - ANGLE_BITS));
      localparam logic [ANGLE_BITS-1:0] A = ROUNDED[32-ANGLE_BITS +: ANGLE_BITS];
      logic signed [CW-1:0] xs, ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            zero_ff[i+1] <= zero_ff[i];
            side_ff[i+1] <= side_ff[i];
            if (!y_ff[i][CW-1]) begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + A;
            end else begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - A;
            end
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_x     = x_ff[N-1];
   assign out_z     = z_ff[N-1];
   assign out_zero  = zero_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

// ===== design/prc_cmd.sv =====
// Command stages: scaling, gains, angular products and saturation.
module prc_cmd import prc_pkg::*; #(
   parameter int unsigned POS_FRAC_BITS = 16,
   parameter int unsigned ANGLE_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  cfg_type               cfg,
   input  logic                  in_valid,
   input  logic signed [CW-1:0]  in_x,
   input  logic [ANGLE_BITS-1:0] in_z,
   input  logic                  in_zero,
   input  logic [ANGLE_BITS-1:0] in_head,
   output logic                  out_valid,
   output logic [POS_W-1:0]      out_distance,
   output logic [POS_W-1:0]      out_linear,
   output logic [POS_W-1:0]      out_angular,
   output logic                  out_reversing,
   output logic                  out_arrived
);

   localparam int unsigned SH = ANGLE_BITS + 28 - POS_FRAC_BITS;
   localparam logic [POS_W-1:0] ARRIVE =
      POS_W'((5 * (64'd1 << POS_FRAC_BITS) + 500) / 1000);
   localparam int unsigned SW = ANGLE_BITS + 18; // signed gain*angle difference
   localparam int unsigned MW = SW + 23;

   // ---- stage A: magnitude product and angle errors
   logic                   a_v_ff;
   logic [CW+29:0]         a_m_ff;
   logic [ANGLE_BITS-1:0]  a_alpha_ff, a_beta_ff;
   logic [ANGLE_BITS-1:0]  h, g, alpha_u, beta_u;
   logic [CW-1:0]          xpos;

   assign h = ANGLE_BITS'({in_head, 8'd0} >> (24 - ANGLE_BITS));
   assign g = ANGLE_BITS'({cfg.goal_heading, 8'd0} >> (24 - ANGLE_BITS));
   assign alpha_u = (in_zero ? '0 : in_z) - h;
   assign beta_u  = g - h - alpha_u;
   assign xpos = (in_zero || in_x < 0) ? '0 : in_x;

   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (adv) a_v_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         a_m_ff     <= (CW+30)'(xpos) * (CW+30)'(INVK_Q30);
         a_alpha_ff <= alpha_u;
         a_beta_ff  <= beta_u;
      end
   end

   // ---- stage B: rho, gain products
   logic                   b_v_ff, b_rev_ff;
   logic [27:0]            b_rho_ff;
   logic signed [SW-1:0]   b_pa_ff, b_pb_ff;
   logic [27:0]            rho;
   logic signed [ANGLE_BITS-1:0] alpha_s, beta_s;
   logic signed [ANGLE_BITS-1:0] quarter;

   assign rho = 28'((a_m_ff + (CW+30)'(64'd1 << 33)) >> 34);
   assign alpha_s = a_alpha_ff;
   assign beta_s  = a_beta_ff;
   assign quarter = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else if (adv) b_v_ff <= a_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         b_rho_ff <= rho;
         b_rev_ff <= (alpha_s > quarter) || (alpha_s < -quarter);
         b_pa_ff  <= SW'(signed'({1'b0, cfg.gain_bearing}) * alpha_s);
         b_pb_ff  <= SW'(signed'({1'b0, cfg.gain_final_heading}) * beta_s);
      end
   end

   // ---- stage C: linear product, angular sum
   logic                   c_v_ff, c_rev_ff, c_neg_ff;
   logic [27:0]            c_rho_ff;
   logic [43:0]            c_lin_ff;
   logic [SW-1:0]          c_mag_ff;
   logic signed [SW-1:0]   s;

   assign s = b_pa_ff - b_pb_ff;

   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else if (adv) c_v_ff <= b_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         c_rho_ff <= b_rho_ff;
         c_rev_ff <= b_rev_ff;
         c_lin_ff <= 44'(b_rho_ff) * 44'(cfg.gain_distance);
         c_neg_ff <= s < 0;
         c_mag_ff <= (s < 0) ? SW'(-s) : SW'(s);
      end
   end

   // ---- stage D: angular product
   logic                   d_v_ff, d_rev_ff, d_neg_ff;
   logic [27:0]            d_rho_ff;
   logic [43:0]            d_lin_ff;
   logic [MW-1:0]          d_w_ff;

   always_ff @(posedge clock) begin
      if (reset) d_v_ff <= 1'b0;
      else if (adv) d_v_ff <= c_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         d_rho_ff <= c_rho_ff;
         d_rev_ff <= c_rev_ff;
         d_neg_ff <= c_neg_ff;
         d_lin_ff <= c_lin_ff;
         d_w_ff   <= MW'(c_mag_ff) * MW'(PI_Q21);
      end
   end

   // ---- stage E: rounding, clamping, signs
   logic [43:0]        v_full;
   logic [MW-1:0]      w_full;
   logic [LIM_W-1:0]   v_sat, w_sat;
   logic [POS_W-1:0]   dist_sat;
   logic               e_v_ff;
   logic [POS_W-1:0]   e_dist_ff, e_lin_ff, e_ang_ff;
   logic               e_rev_ff, e_arr_ff;

   assign v_full = (d_lin_ff + 44'd128) >> 8;
   assign w_full = (d_w_ff + (MW'(1) << (SH - 1))) >> SH;
   assign v_sat  = (v_full > 44'(cfg.max_linear)) ? cfg.max_linear : LIM_W'(v_full);
   assign w_sat  = (w_full > MW'(cfg.max_angular)) ? cfg.max_angular : LIM_W'(w_full);
   assign dist_sat = (d_rho_ff > 28'hFFFFFF) ? 24'hFFFFFF : POS_W'(d_rho_ff);

   always_ff @(posedge clock) begin
      if (reset) e_v_ff <= 1'b0;
      else if (adv) e_v_ff <= d_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         e_dist_ff <= dist_sat;
         e_lin_ff  <= d_rev_ff ? -POS_W'(v_sat) : POS_W'(v_sat);
         e_ang_ff  <= d_neg_ff ? -POS_W'(w_sat) : POS_W'(w_sat);
         e_rev_ff  <= d_rev_ff;
         e_arr_ff  <= dist_sat <= ARRIVE;
      end
   end

   assign out_valid     = e_v_ff;
   assign out_distance  = e_dist_ff;
   assign out_linear    = e_lin_ff;
   assign out_angular   = e_ang_ff;
   assign out_reversing = e_rev_ff;
   assign out_arrived   = e_arr_ff;

endmodule

// ===== design/pose_regulation_controller_top.sv =====
// Top level of the pose regulation controller.
// Takes one measured pose per clock and returns distance, linear and angular
// commands, reversing and arrived flags for the configured goal. The pipeline
// is one input register, a fold stage, one stage per CORDIC micro-rotation and
// five command stages; throughput is one pose per clock while no result is
// stalled, set by the fully pipelined CORDIC. A stall on rsp_ freezes the
// whole pipeline; req_stall is rsp_stall when the pipe is full at its end.
// Configuration writes are always accepted (csr_ready is tied high) and must
// be issued only while no pose is in flight.
module pose_regulation_controller_top import prc_pkg::*; #(
   parameter int unsigned POS_FRAC_BITS = 16,
   parameter int unsigned ANGLE_BITS    = 16,
   parameter int unsigned CORDIC_STAGES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [HEAD_W-1:0] req_heading,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [POS_W-1:0]         rsp_distance,
   output logic signed [POS_W-1:0]  rsp_linear_cmd,
   output logic signed [POS_W-1:0]  rsp_angular_cmd,
   output logic                     rsp_reversing,
   output logic                     rsp_arrived,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DAT_W-1:0]     csr_data
);

   cfg_type cfg_ff;
   logic    adv;

   // whole pipe moves unless a result is held at the output
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_distance      <= 16'd2304;
         cfg_ff.gain_bearing       <= 16'd3840;
         cfg_ff.gain_final_heading <= 16'd768;
         cfg_ff.goal_x             <= '0;
         cfg_ff.goal_y             <= '0;
         cfg_ff.goal_heading       <= '0;
         cfg_ff.max_linear         <= 23'd983040;
         cfg_ff.max_angular        <= 23'd655360;
      end else if (csr_valid && !csr_index[CSR_IDX_W-1]) begin
         unique case (csr_index_type'(csr_index[2:0]))
            CSR_GAIN_DISTANCE:      cfg_ff.gain_distance      <= csr_data[15:0];
            CSR_GAIN_BEARING:       cfg_ff.gain_bearing       <= csr_data[15:0];
            CSR_GAIN_FINAL_HEADING: cfg_ff.gain_final_heading <= csr_data[15:0];
            CSR_GOAL_X:             cfg_ff.goal_x             <= csr_data;
            CSR_GOAL_Y:             cfg_ff.goal_y             <= csr_data;
            CSR_GOAL_HEADING:       cfg_ff.goal_heading       <= csr_data[15:0];
            CSR_MAX_LINEAR:         cfg_ff.max_linear         <= csr_data[22:0];
            CSR_MAX_ANGULAR:        cfg_ff.max_angular        <= csr_data[22:0];
            default: ;
         endcase
      end
   end

   // Input stage: position error, scaled by 16
   logic                  in_v_ff, in_zero_ff;
   logic signed [CW-1:0]  in_x_ff, in_y_ff;
   logic [HEAD_W-1:0]     in_h_ff;
   logic signed [POS_W:0] dx, dy;

   assign dx = {cfg_ff.goal_x[POS_W-1], cfg_ff.goal_x} - {req_pos_x[POS_W-1], req_pos_x};
   assign dy = {cfg_ff.goal_y[POS_W-1], cfg_ff.goal_y} - {req_pos_y[POS_W-1], req_pos_y};

   always_ff @(posedge clock) begin
      if (reset) in_v_ff <= 1'b0;
      else if (adv) in_v_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         in_x_ff    <= {{(CW-POS_W-5){dx[POS_W]}}, dx, 4'd0};
         in_y_ff    <= {{(CW-POS_W-5){dy[POS_W]}}, dy, 4'd0};
         in_zero_ff <= (dx == '0) && (dy == '0);
         in_h_ff    <= req_heading;
      end
   end

   logic                  cv, czero;
   logic signed [CW-1:0]  cx;
   logic [ANGLE_BITS-1:0] cz;
   logic [HEAD_W-1:0]     chead;

   prc_cordic #(
      .ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES), .SIDE_W(HEAD_W)
   ) u_cordic (
      .clock, .reset, .adv,
      .in_valid(in_v_ff), .in_x(in_x_ff), .in_y(in_y_ff),
      .in_zero(in_zero_ff), .in_side(in_h_ff),
      .out_valid(cv), .out_x(cx), .out_z(cz), .out_zero(czero), .out_side(chead)
   );

   logic [POS_W-1:0] lin_u, ang_u;

   prc_cmd #(
      .POS_FRAC_BITS(POS_FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)
   ) u_cmd (
      .clock, .reset, .adv, .cfg(cfg_ff),
      .in_valid(cv), .in_x(cx), .in_z(cz), .in_zero(czero), .in_head(chead),
      .out_valid(rsp_valid), .out_distance(rsp_distance),
      .out_linear(lin_u), .out_angular(ang_u),
      .out_reversing(rsp_reversing), .out_arrived(rsp_arrived)
   );

   assign rsp_linear_cmd  = lin_u;
   assign rsp_angular_cmd = ang_u;

endmodule

// ===== design/prc_checker.sv =====
// Port-level checker for the pose regulation controller, with its bind.
module prc_checker import prc_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [POS_W-1:0] rsp_distance,
   input logic [POS_W-1:0] rsp_linear_cmd,
   input logic             rsp_reversing,
   input logic             rsp_arrived
);

   // input is held off only while a result waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without stalled result");

   // a stalled result stays valid and holds its distance
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_distance)))
      else $error("stalled result changed");

   // arrived implies a small distance
   a_arrived: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_arrived) |-> (rsp_distance < 24'd65536))
      else $error("arrived with large distance");

   // a forward command is never negative
   a_fwd_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_reversing) |-> !rsp_linear_cmd[POS_W-1])
      else $error("negative forward command");

   // no result straight out of reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

endmodule

bind pose_regulation_controller_top prc_checker u_prc_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_distance, .rsp_linear_cmd, .rsp_reversing, .rsp_arrived
);

// ===== test/prc_checker.sv =====
// Checker for the pose regulation controller: predicts each response and compares.
module prc_scoreboard import prc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [HEAD_W-1:0] req_heading,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [POS_W-1:0]         rsp_distance,
   input  logic signed [POS_W-1:0]  rsp_linear_cmd,
   input  logic signed [POS_W-1:0]  rsp_angular_cmd,
   input  logic                     rsp_reversing,
   input  logic                     rsp_arrived,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DAT_W-1:0]     csr_data,
   output int                       fail_count,
   output int                       pending
);

   typedef struct packed {
      logic [23:0] distance;
      logic [23:0] linear_cmd;
      logic [23:0] angular_cmd;
      logic        reversing;
      logic        arrived;
   } command_type;

   localparam longint ARRIVE_LIMIT = 328;

   cfg_type     cfg;
   command_type command_queue[$];

   // sign extension at a given width
   function automatic longint sx(longint v, int w);
      longint m;
      m = (64'sd1 <<< w) - 1;
      v = v & m;
      if (v[w-1]) v = v - (64'sd1 <<< w);
      return v;
   endfunction

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   // command for one pose against the current goal and gains
   function automatic command_type steer_to_goal(logic [23:0] px, logic [23:0] py,
                                                 logic [15:0] hd);
      command_type c;
      longint dx, dy, x, y, nx, ny, alpha, beta, s;
      longint unsigned z, rho, bear, a, h, g, au, bu, v, w, mag, dist_sat;
      bit rev;
      dx = sx(cfg.goal_x, 24) - sx(px, 24);
      dy = sx(cfg.goal_y, 24) - sx(py, 24);
      rho = 0;
      bear = 0;
      if (dx != 0 || dy != 0) begin
         x = dx * 16;
         y = dy * 16;
         z = 0;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'd32768;
         end
         for (int i = 0; i < 16; i++) begin
            a = (64'(ATAN_TURN32[i]) + 64'd32768) >> 16;
            if (y >= 0) begin
               nx = x + shr_floor(y, i);
               ny = y - shr_floor(x, i);
               z = z + a;
            end else begin
               nx = x - shr_floor(y, i);
               ny = y + shr_floor(x, i);
               z = z - a;
            end
            x = nx;
            y = ny;
         end
         if (x < 0) x = 0;
         rho = (longint'(x) * 64'd652032874 + (64'd1 << 33)) >> 34;
         bear = z & 64'hFFFF;
      end
      h = hd;
      g = cfg.goal_heading;
      au = (bear - h) & 64'hFFFF;
      bu = (g - h - au) & 64'hFFFF;
      alpha = sx(au, 16);
      beta = sx(bu, 16);
      rev = (alpha > 16384) || (alpha < -16384);
      v = (64'(cfg.gain_distance) * rho + 128) >> 8;
      if (v > cfg.max_linear) v = cfg.max_linear;
      if (rev) v = -v;
      s = longint'(cfg.gain_bearing) * alpha - longint'(cfg.gain_final_heading) * beta;
      mag = (s < 0) ? -s : s;
      w = (mag * 64'd6588397 + (64'd1 << 27)) >> 28;
      if (w > cfg.max_angular) w = cfg.max_angular;
      if (s < 0) w = -w;
      dist_sat = (rho > 64'hFFFFFF) ? 64'hFFFFFF : rho;
      c.distance = dist_sat[23:0];
      c.linear_cmd = v[23:0];
      c.angular_cmd = w[23:0];
      c.reversing = rev;
      c.arrived = (dist_sat <= ARRIVE_LIMIT);
      return c;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   assign pending = command_queue.size();

   // register shadow, prediction and comparison
   always @(posedge clock) begin
      command_type want;
      if (reset) begin
         cfg.gain_distance      <= 16'd2304;
         cfg.gain_bearing       <= 16'd3840;
         cfg.gain_final_heading <= 16'd768;
         cfg.goal_x             <= '0;
         cfg.goal_y             <= '0;
         cfg.goal_heading       <= '0;
         cfg.max_linear         <= 23'd983040;
         cfg.max_angular        <= 23'd655360;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN_DISTANCE:      cfg.gain_distance <= csr_data[15:0];
               CSR_GAIN_BEARING:       cfg.gain_bearing <= csr_data[15:0];
               CSR_GAIN_FINAL_HEADING: cfg.gain_final_heading <= csr_data[15:0];
               CSR_GOAL_X:             cfg.goal_x <= csr_data;
               CSR_GOAL_Y:             cfg.goal_y <= csr_data;
               CSR_GOAL_HEADING:       cfg.goal_heading <= csr_data[15:0];
               CSR_MAX_LINEAR:         cfg.max_linear <= csr_data[22:0];
               CSR_MAX_ANGULAR:        cfg.max_angular <= csr_data[22:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            command_queue.push_back(steer_to_goal(req_pos_x, req_pos_y, req_heading));
         if (rsp_valid && !rsp_stall) begin
            if (command_queue.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_distance, 0);
            end else begin
               want = command_queue.pop_front();
               if (rsp_distance !== want.distance)
                  report_mismatch("distance", rsp_distance, want.distance);
               if (rsp_linear_cmd !== want.linear_cmd)
                  report_mismatch("linear_cmd", rsp_linear_cmd, want.linear_cmd);
               if (rsp_angular_cmd !== want.angular_cmd)
                  report_mismatch("angular_cmd", rsp_angular_cmd, want.angular_cmd);
               if (rsp_reversing !== want.reversing)
                  report_mismatch("reversing", rsp_reversing, want.reversing);
               if (rsp_arrived !== want.arrived)
                  report_mismatch("arrived", rsp_arrived, want.arrived);
            end
         end
      end
   end

endmodule

// ===== test/tb_pose_regulation_controller_top.sv =====
// Testbench top: clock, reset, pose and register stimulus, final verdict.
module tb_pose_regulation_controller_top import prc_pkg::*;;

   localparam int LATENCY = 23;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [CSR_IDX_W-1:0] UNMAPPED_INDEX = '1;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic signed [POS_W-1:0] req_pos_x, req_pos_y;
   logic signed [HEAD_W-1:0] req_heading;
   logic [POS_W-1:0] rsp_distance;
   logic signed [POS_W-1:0] rsp_linear_cmd, rsp_angular_cmd;
   logic rsp_reversing, rsp_arrived;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;
   int fail_count, pending, cycles;
   bit quiet;

   pose_regulation_controller_top dut (.*);

   prc_scoreboard checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_pose_regulation_controller_top failed");
         $finish;
      end
   end

   // receiver stall in random bursts
   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_stall <= 0;
         end
      end
   end

   // valid stays high between back-to-back writes; cleared by the next activity
   task automatic write_raw(logic [CSR_IDX_W-1:0] idx, logic [23:0] value);
      req_valid <= 0;
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [23:0] value);
      write_raw(CSR_IDX_W'(idx), value);
   endtask

   task automatic send_pose(logic [23:0] px, logic [23:0] py, logic [15:0] hd);
      csr_valid <= 0;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid   <= 1;
      req_pos_x   <= px;
      req_pos_y   <= py;
      req_heading <= hd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      csr_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // pose near the goal with small, medium or full-range offsets
   function automatic logic [23:0] near(logic [23:0] goal);
      case ($urandom_range(0, 3))
         0: return goal + 24'($signed($urandom_range(0, 800)) - 400);
         1: return goal + 24'($signed($urandom_range(0, 400000)) - 200000);
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic random_setting(bit extreme);
      write_reg(CSR_GAIN_DISTANCE, extreme ? 24'hFFFF : 24'($urandom_range(0, 8000)));
      write_reg(CSR_GAIN_BEARING, extreme ? 24'hFFFF : 24'($urandom_range(0, 8000)));
      write_reg(CSR_GAIN_FINAL_HEADING, extreme ? 24'h0 : 24'($urandom_range(0, 65535)));
      write_reg(CSR_GOAL_X, 24'($urandom));
      write_reg(CSR_GOAL_Y, 24'($urandom));
      write_reg(CSR_GOAL_HEADING, 24'($urandom_range(0, 65535)));
      write_reg(CSR_MAX_LINEAR, extreme ? 24'h7FFFFF : 24'($urandom_range(0, 24'h7FFFFF)));
      write_reg(CSR_MAX_ANGULAR, extreme ? 24'h0 : 24'($urandom_range(0, 24'h7FFFFF)));
   endtask

   initial begin
      reset = 1;
      quiet = 0;
      req_valid = 0;
      req_pos_x = 0;
      req_pos_y = 0;
      req_heading = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_data = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: goal reached, arrival edge, extremes, every quadrant, reversing
      send_pose(24'h0, 24'h0, 16'h0);
      send_pose(24'd328, 24'h0, 16'h0);
      send_pose(-24'sd329, 24'h0, 16'h8000);
      send_pose(24'h800000, 24'h800000, 16'h7FFF);
      send_pose(24'h7FFFFF, 24'h7FFFFF, 16'h8000);
      send_pose(24'h800000, 24'h7FFFFF, 16'hFFFF);
      send_pose(24'h7FFFFF, 24'h800000, 16'h4000);
      send_pose(24'h010000, 24'h0, 16'h0);
      send_pose(-24'sh010000, 24'h0, 16'h0);
      send_pose(24'h0, 24'h010000, 16'hC000);
      send_pose(24'h0, -24'sh010000, 16'h4000);
      send_pose(24'hFFFFFF, 24'h000001, 16'h0001);
      drain();
      // far goal, saturating commands
      write_reg(CSR_GOAL_X, 24'h7FFFFF);
      write_reg(CSR_GOAL_Y, 24'h7FFFFF);
      write_reg(CSR_GOAL_HEADING, 24'h8000);
      write_reg(CSR_GAIN_DISTANCE, 24'hFFFF);
      write_reg(CSR_GAIN_BEARING, 24'hFFFF);
      write_reg(CSR_MAX_LINEAR, 24'h7FFFFF);
      write_reg(CSR_MAX_ANGULAR, 24'h7FFFFF);
      write_raw(UNMAPPED_INDEX, 24'h123456);
      send_pose(24'h800000, 24'h800000, 16'h0);
      send_pose(24'h800000, 24'h7FFFFF, 16'h7FFF);
      send_pose(24'h7FFFFF, 24'h800000, 16'h8000);
      send_pose(24'h7FFFFF, 24'h7FFFFF, 16'h1234);
      drain();

      // random phases under varied settings
      for (int phase = 0; phase < 8; phase++) begin
         random_setting(phase == 2);
         if (phase == 7) quiet = 1;
         for (int n = 0; n < 100; n++)
            send_pose(near(checker_i.cfg.goal_x), near(checker_i.cfg.goal_y),
                      16'($urandom));
         // sender holds off until everything is back
         drain();
      end

      if (fail_count == 0)
         $display("tb_pose_regulation_controller_top passed");
      else
         $display("tb_pose_regulation_controller_top failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/prc_pkg.sv
design/prc_cordic.sv
design/prc_cmd.sv
design/pose_regulation_controller_top.sv
design/prc_checker.sv
test/prc_checker.sv
test/tb_pose_regulation_controller_top.sv
